// ----- rtl/core/convex_hull_of_point_set_unit_assert.svh -----
// Assertion macros for the checker file of the convex hull unit.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef CONVEX_HULL_OF_POINT_SET_UNIT_ASSERT_SVH
`define CONVEX_HULL_OF_POINT_SET_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CHP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hull unit check failed");

// next-cycle implication, disabled in reset
`define CHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hull unit check failed");

`endif

// ----- rtl/core/chp_pkg.sv -----
// Package of the convex hull unit: sizes, point entry type and the
// request/result structs of the geometry unit. No dependencies.
package chp_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 32;
  localparam int COORD_SH   = 32 - COORD_BITS;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int MIN_HULL   = 3;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pt_t;

  localparam int PT_W = $bits(pt_t);

  typedef struct packed {
    logic start;
    pt_t  o;
    pt_t  a;
    pt_t  b;
  } geo_req_t;

  typedef struct packed {
    logic done;
    logic cross_pos;
    logic cross_zero;
    logic dist_lt;
  } geo_res_t;

endpackage

// ----- rtl/core/chp_if.sv -----
// Handshake interfaces of the convex hull unit: point words in, hull words out.
// Depends on nothing.
interface chp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic               last_point;
  modport source (output valid, x_coord, y_coord, last_point, input ready);
  modport sink   (input valid, x_coord, y_coord, last_point, output ready);
  modport mon    (input valid, ready, x_coord, y_coord, last_point);
endinterface

interface chp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] hull_x;
  logic signed [31:0] hull_y;
  logic [5:0]         point_index;
  logic               overflow;
  logic               last_vertex;
  modport source (output valid, hull_x, hull_y, point_index, overflow, last_vertex,
                  input ready);
  modport sink   (input valid, hull_x, hull_y, point_index, overflow, last_vertex,
                  output ready);
  modport mon    (input valid, ready, hull_x, hull_y, point_index, overflow,
                  last_vertex);
endinterface

// ----- rtl/core/chp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/chp_geom.sv -----
// Geometry unit: exact cross product sign and squared-distance compare of
// two points about an origin, six products through one 32x32 multiplier.
// Depends on chp_pkg.
module chp_geom (
  input  logic             clk,
  input  logic             rst_n,
  input  chp_pkg::geo_req_t req,
  output chp_pkg::geo_res_t res
);

  logic signed [32:0] dxa_r, dya_r, dxb_r, dyb_r;
  logic signed [32:0] m1, m2;
  logic [31:0]        mag1, mag2;
  logic [63:0]        prod_r;
  logic               neg_r;
  logic signed [65:0] sp;
  logic signed [65:0] cr_r;
  logic [64:0]        da_r, db_r;
  logic [2:0]         st_r;
  logic               busy_r, done_r;

  always_comb begin
    case (st_r)
      3'd0:    begin m1 = dxa_r; m2 = dyb_r; end
      3'd1:    begin m1 = dya_r; m2 = dxb_r; end
      3'd2:    begin m1 = dxa_r; m2 = dxa_r; end
      3'd3:    begin m1 = dya_r; m2 = dya_r; end
      3'd4:    begin m1 = dxb_r; m2 = dxb_r; end
      default: begin m1 = dyb_r; m2 = dyb_r; end
    endcase
    mag1 = m1[32] ? 32'(-m1) : m1[31:0];
    mag2 = m2[32] ? 32'(-m2) : m2[31:0];
    sp   = neg_r ? -$signed({2'b00, prod_r}) : $signed({2'b00, prod_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      st_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        st_r   <= '0;
      end else if (busy_r) begin
        st_r <= st_r + 3'd1;
        if (st_r == 3'd6) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and accumulators
  always_ff @(posedge clk) begin
    if (req.start) begin
      dxa_r <= {req.a.x[31], req.a.x} - {req.o.x[31], req.o.x};
      dya_r <= {req.a.y[31], req.a.y} - {req.o.y[31], req.o.y};
      dxb_r <= {req.b.x[31], req.b.x} - {req.o.x[31], req.o.x};
      dyb_r <= {req.b.y[31], req.b.y} - {req.o.y[31], req.o.y};
    end
    prod_r <= mag1 * mag2;
    neg_r  <= m1[32] ^ m2[32];
    if (busy_r) begin
      case (st_r)
        3'd1:    cr_r <= sp;
        3'd2:    cr_r <= cr_r - sp;
        3'd3:    da_r <= {1'b0, prod_r};
        3'd4:    da_r <= da_r + {1'b0, prod_r};
        3'd5:    db_r <= {1'b0, prod_r};
        3'd6:    db_r <= db_r + {1'b0, prod_r};
        default: ;
      endcase
    end
  end

  assign res.done       = done_r;
  assign res.cross_pos  = !cr_r[65] && (cr_r != '0);
  assign res.cross_zero = (cr_r == '0);
  assign res.dist_lt    = (da_r < db_r);

endmodule

// ----- rtl/core/convex_hull_of_point_set_unit.sv -----
// Convex hull unit (Graham scan). Points are taken one word per cycle into the
// point RAM; the word marked last_point closes the set. Then, with the input
// held off: pivot search, a read and a compare per point; insertion sort,
// which fetches each point, compares it down the sorted entries and places it;
// stack scan, with a turn test per point once two are on the stack and a pop
// for each turn that is not to the left; then the hull words, each held until
// the sink takes it. The exact geometry unit is shared by sort and scan, and
// each RAM has a single read port. Sets of fewer than three points come back
// in arrival order. Points beyond 64 are dropped and overflow is raised on
// every word of that hull.
module convex_hull_of_point_set_unit (
  input  logic          clk,
  input  logic          rst_n,
  chp_in_if.sink        in_pt,
  chp_out_if.source     out_hull
);

  localparam logic [4:0] ST_LOAD    = 5'd0;
  localparam logic [4:0] ST_PV_RD   = 5'd1;
  localparam logic [4:0] ST_PV_CMP  = 5'd2;
  localparam logic [4:0] ST_PV_WR   = 5'd3;
  localparam logic [4:0] ST_S_FETCH = 5'd4;
  localparam logic [4:0] ST_S_CAND  = 5'd5;
  localparam logic [4:0] ST_S_RD    = 5'd6;
  localparam logic [4:0] ST_S_ENT   = 5'd7;
  localparam logic [4:0] ST_S_CMP   = 5'd8;
  localparam logic [4:0] ST_S_GEO   = 5'd9;
  localparam logic [4:0] ST_S_WR    = 5'd10;
  localparam logic [4:0] ST_C_RD    = 5'd11;
  localparam logic [4:0] ST_C_CAND  = 5'd12;
  localparam logic [4:0] ST_C_CHK   = 5'd13;
  localparam logic [4:0] ST_C_GEO   = 5'd14;
  localparam logic [4:0] ST_C_SEC   = 5'd15;
  localparam logic [4:0] ST_C_SECW  = 5'd16;
  localparam logic [4:0] ST_O_RD    = 5'd17;
  localparam logic [4:0] ST_O_LD    = 5'd18;
  localparam logic [4:0] ST_O_WAIT  = 5'd19;

  localparam int IW = chp_pkg::IDX_W;
  localparam int CW = chp_pkg::CNT_W;

  logic [4:0]    st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] hs_r, hs_nxt;
  logic          small_r, small_nxt;
  logic          ov_r, ov_nxt;
  logic          olast_r, olast_nxt;
  chp_pkg::pt_t  pv_r, pv_nxt;
  chp_pkg::pt_t  cand_r, cand_nxt;
  chp_pkg::pt_t  ent_r, ent_nxt;
  chp_pkg::pt_t  top_r, top_nxt;
  chp_pkg::pt_t  sec_r, sec_nxt;
  chp_pkg::pt_t  ox_r, ox_nxt;

  // RAM ports
  logic          pt_we, srt_we, stk_we;
  logic [IW-1:0] pt_waddr, srt_waddr, stk_waddr;
  logic [IW-1:0] pt_raddr, srt_raddr, stk_raddr;
  chp_pkg::pt_t  pt_wdata, srt_wdata, stk_wdata;
  chp_pkg::pt_t  pt_rdata, srt_rdata, stk_rdata;

  chp_pkg::geo_req_t geo_req;
  chp_pkg::geo_res_t geo_res;

  logic          in_acc;
  logic          za, zb, do_shift, do_push;
  logic [CW-1:0] total;
  chp_pkg::pt_t  rd_pt;

  chp_ram #(.WIDTH(chp_pkg::PT_W), .DEPTH(chp_pkg::MAX_POINTS)) u_pt_ram (
    .clk, .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  chp_ram #(.WIDTH(chp_pkg::PT_W), .DEPTH(chp_pkg::MAX_POINTS)) u_srt_ram (
    .clk, .we(srt_we), .waddr(srt_waddr), .wdata(srt_wdata),
    .raddr(srt_raddr), .rdata(srt_rdata)
  );

  chp_ram #(.WIDTH(chp_pkg::PT_W), .DEPTH(chp_pkg::MAX_POINTS)) u_stk_ram (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  chp_geom u_geom (.clk, .rst_n, .req(geo_req), .res(geo_res));

  assign in_pt.ready = (st_r == ST_LOAD);
  assign in_acc      = in_pt.valid && in_pt.ready;

  // a point equal to the pivot has no angle: it sorts first
  assign za    = (cand_r.x == pv_r.x) && (cand_r.y == pv_r.y);
  assign zb    = (ent_r.x == pv_r.x) && (ent_r.y == pv_r.y);
  assign total = small_r ? cnt_r : hs_r;
  assign rd_pt = pt_rdata;

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    hs_nxt    = hs_r;
    small_nxt = small_r;
    ov_nxt    = ov_r;
    olast_nxt = olast_r;
    pv_nxt    = pv_r;
    cand_nxt  = cand_r;
    ent_nxt   = ent_r;
    top_nxt   = top_r;
    sec_nxt   = sec_r;
    ox_nxt    = ox_r;
    pt_we     = 1'b0;
    pt_waddr  = cnt_r[IW-1:0];
    pt_wdata  = '0;
    pt_raddr  = i_r[IW-1:0];
    srt_we    = 1'b0;
    srt_waddr = pos_r[IW-1:0];
    srt_wdata = cand_r;
    srt_raddr = i_r[IW-1:0];
    stk_we    = 1'b0;
    stk_waddr = hs_r[IW-1:0];
    stk_wdata = cand_r;
    stk_raddr = i_r[IW-1:0];
    geo_req   = '0;
    do_shift  = 1'b0;
    do_push   = 1'b0;

    unique case (st_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CW'(chp_pkg::MAX_POINTS)) begin
            pt_we      = 1'b1;
            pt_wdata.idx = cnt_r[IW-1:0];
            pt_wdata.x = $signed(in_pt.x_coord <<< chp_pkg::COORD_SH) >>> chp_pkg::COORD_SH;
            pt_wdata.y = $signed(in_pt.y_coord <<< chp_pkg::COORD_SH) >>> chp_pkg::COORD_SH;
            cnt_nxt    = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_pt.last_point) begin
            i_nxt = '0;
            if (cnt_nxt < CW'(chp_pkg::MIN_HULL)) begin
              small_nxt = 1'b1;
              st_nxt    = ST_O_RD;
            end else begin
              small_nxt = 1'b0;
              st_nxt    = ST_PV_RD;
            end
          end
        end
      end
      ST_PV_RD: st_nxt = ST_PV_CMP;
      ST_PV_CMP: begin
        // lowest y, then smallest x; strict compare keeps the earliest
        if (i_r == '0 || rd_pt.y < pv_r.y || (rd_pt.y == pv_r.y && rd_pt.x < pv_r.x)) begin
          pv_nxt = rd_pt;
        end
        i_nxt  = i_r + CW'(1);
        st_nxt = (i_nxt == cnt_r) ? ST_PV_WR : ST_PV_RD;
      end
      ST_PV_WR: begin
        srt_we    = 1'b1;
        srt_waddr = '0;
        srt_wdata = pv_r;
        k_nxt     = CW'(1);
        i_nxt     = '0;
        st_nxt    = ST_S_FETCH;
      end
      ST_S_FETCH: begin
        if (i_r == cnt_r) begin
          i_nxt  = '0;
          hs_nxt = '0;
          st_nxt = ST_C_RD;
        end else if (i_r[IW-1:0] == pv_r.idx) begin
          i_nxt = i_r + CW'(1);
        end else begin
          st_nxt = ST_S_CAND;
        end
      end
      ST_S_CAND: begin
        cand_nxt = pt_rdata;
        pos_nxt  = k_r;
        st_nxt   = (k_r > CW'(1)) ? ST_S_RD : ST_S_WR;
      end
      ST_S_RD: begin
        srt_raddr = IW'(pos_r - CW'(1));
        st_nxt    = ST_S_ENT;
      end
      ST_S_ENT: begin
        ent_nxt = srt_rdata;
        st_nxt  = ST_S_CMP;
      end
      ST_S_CMP: begin
        if (za || zb) begin
          if (za && !zb) do_shift = 1'b1;
          else st_nxt = ST_S_WR;
        end else begin
          geo_req.start = 1'b1;
          geo_req.o     = pv_r;
          geo_req.a     = cand_r;
          geo_req.b     = ent_r;
          st_nxt        = ST_S_GEO;
        end
      end
      ST_S_GEO: begin
        if (geo_res.done) begin
          if (geo_res.cross_pos || (geo_res.cross_zero && geo_res.dist_lt)) do_shift = 1'b1;
          else st_nxt = ST_S_WR;
        end
      end
      ST_S_WR: begin
        srt_we = 1'b1;
        k_nxt  = k_r + CW'(1);
        i_nxt  = i_r + CW'(1);
        st_nxt = ST_S_FETCH;
      end
      ST_C_RD: st_nxt = ST_C_CAND;
      ST_C_CAND: begin
        cand_nxt = srt_rdata;
        st_nxt   = ST_C_CHK;
      end
      ST_C_CHK: begin
        if (hs_r >= CW'(2)) begin
          geo_req.start = 1'b1;
          geo_req.o     = sec_r;
          geo_req.a     = top_r;
          geo_req.b     = cand_r;
          st_nxt        = ST_C_GEO;
        end else begin
          do_push = 1'b1;
        end
      end
      ST_C_GEO: begin
        if (geo_res.done) begin
          if (geo_res.cross_pos) begin
            do_push = 1'b1;
          end else begin
            top_nxt = sec_r;
            hs_nxt  = hs_r - CW'(1);
            st_nxt  = (hs_nxt >= CW'(2)) ? ST_C_SEC : ST_C_CHK;
          end
        end
      end
      ST_C_SEC: begin
        stk_raddr = IW'(hs_r - CW'(2));
        st_nxt    = ST_C_SECW;
      end
      ST_C_SECW: begin
        sec_nxt = stk_rdata;
        st_nxt  = ST_C_CHK;
      end
      ST_O_RD: st_nxt = ST_O_LD;
      ST_O_LD: begin
        ox_nxt    = small_r ? pt_rdata : stk_rdata;
        olast_nxt = (i_r + CW'(1) == total);
        ov_nxt    = 1'b1;
        st_nxt    = ST_O_WAIT;
      end
      ST_O_WAIT: begin
        if (out_hull.ready) begin
          ov_nxt = 1'b0;
          if (olast_r) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            hs_nxt  = '0;
            st_nxt  = ST_LOAD;
          end else begin
            i_nxt  = i_r + CW'(1);
            st_nxt = ST_O_RD;
          end
        end
      end
      default: st_nxt = ST_LOAD;
    endcase

    // move the compared entry up one place and keep searching downward
    if (do_shift) begin
      srt_we    = 1'b1;
      srt_wdata = ent_r;
      pos_nxt   = pos_r - CW'(1);
      st_nxt    = (pos_nxt > CW'(1)) ? ST_S_RD : ST_S_WR;
    end

    // push the candidate; top and second stay in registers
    if (do_push) begin
      stk_we  = 1'b1;
      sec_nxt = top_r;
      top_nxt = cand_r;
      hs_nxt  = hs_r + CW'(1);
      i_nxt   = i_r + CW'(1);
      if (i_nxt == cnt_r) begin
        i_nxt  = '0;
        st_nxt = ST_O_RD;
      end else begin
        st_nxt = ST_C_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      k_r     <= '0;
      pos_r   <= '0;
      hs_r    <= '0;
      small_r <= 1'b0;
      ov_r    <= 1'b0;
      olast_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      pos_r   <= pos_nxt;
      hs_r    <= hs_nxt;
      small_r <= small_nxt;
      ov_r    <= ov_nxt;
      olast_r <= olast_nxt;
    end
  end

  // payload registers hold without reset
  always_ff @(posedge clk) begin
    pv_r   <= pv_nxt;
    cand_r <= cand_nxt;
    ent_r  <= ent_nxt;
    top_r  <= top_nxt;
    sec_r  <= sec_nxt;
    ox_r   <= ox_nxt;
  end

  assign out_hull.valid       = ov_r;
  assign out_hull.hull_x      = ox_r.x;
  assign out_hull.hull_y      = ox_r.y;
  assign out_hull.point_index = 6'(ox_r.idx);
  assign out_hull.overflow    = ovf_r;
  assign out_hull.last_vertex = olast_r;

endmodule

// ----- rtl/core/chp_chk.sv -----
// Port checker of the convex hull unit and its bind to the top level.
// Depends on the assertion macro header.
`include "convex_hull_of_point_set_unit_assert.svh"

module chp_chk (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // no point word is taken while a hull word waits
  `CHP_ASSERT_NOW(a_no_load_in_output, out_valid, !in_ready)

  // a waiting hull word stays offered
  `CHP_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid)

  // the last vertex ends the set: loading resumes at once
  `CHP_ASSERT_NEXT(a_last_ends_set, out_valid && out_ready && out_last, !out_valid && in_ready)

endmodule

bind convex_hull_of_point_set_unit chp_chk u_chp_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_pt.ready), .out_valid(out_hull.valid),
  .out_ready(out_hull.ready), .out_last(out_hull.last_vertex)
);
